// ===== rtl/core/radial_collision_cost_stamp_assert.svh =====
// Assertion macros used by the radial collision cost stamp top level.
`ifndef RADIAL_COLLISION_COST_STAMP_ASSERT_SVH
`define RADIAL_COLLISION_COST_STAMP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define RCCS_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("rccs assertion failed");
// Checked at every edge, reset included.
`define RCCS_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("rccs assertion failed");
`else
`define RCCS_ASSERT(lbl, clk_s, rstn_s, prop)
`define RCCS_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

// ===== rtl/core/rccs_pkg.sv =====
// Types and constants of the radial collision cost stamp.
package rccs_pkg;
  localparam int IDX_W   = 12;
  localparam int COST_W  = 8;
  localparam int RAD_W   = 20;
  localparam int AX_W    = 22;
  localparam int SQ_W    = 44;
  localparam int S_W     = 45;
  localparam int T_W     = 61;
  localparam int CR_W    = 30;
  localparam int K_W     = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER_RADIUS = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_X = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ORIGIN_Y = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE     = 8'd6;

  localparam logic [15:0] CELL_SIZE_RST = 16'd51;
  localparam logic [15:0] COST_SCALE_SQ = 16'd65025;
  localparam logic [K_W:0] K_LIMIT      = 11'd765;
  localparam logic [K_W:0] COST_MAX     = 11'd255;

  typedef struct packed {
    logic               en;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [RAD_W-1:0]   r;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [15:0]        csize;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [COST_W-1:0] old;
    logic              skip;
    logic [T_W-1:0]    t;
    logic [K_W-1:0]    acc;
    logic [CR_W-1:0]   acc_cr;
  } srch_t;
endpackage

// ===== rtl/core/rccs_if.sv =====
// Channel interfaces of the radial collision cost stamp.
interface rccs_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] cell_col;
  logic [11:0] cell_row;
  logic [7:0]  old_cost;
  modport source (output valid, cell_col, cell_row, old_cost, input ready);
  modport sink (input valid, cell_col, cell_row, old_cost, output ready);
endinterface

interface rccs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_col;
  logic [11:0] out_row;
  logic [7:0]  new_cost;
  modport source (output valid, out_col, out_row, new_cost, input ready);
  modport sink (input valid, out_col, out_row, new_cost, output ready);
endinterface

interface rccs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rccs_front.sv =====
// Front stages: cell center offsets, squares and the scaled squared distance.
module rccs_front import rccs_pkg::*; #(
  parameter int GRID_DIM = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [COST_W-1:0] in_old,
  output logic              out_valid,
  input  logic              out_ready,
  output srch_t             out_item
);
  localparam logic [16:0] GRID_LIM = 17'(GRID_DIM);

  logic [4:0] v_r;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = out_ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage 1: doubled cell center offset (2*index+1)*cell_size.
  logic [IDX_W-1:0]  s1_col_r, s1_row_r;
  logic [COST_W-1:0] s1_old_r;
  logic              s1_skip_r;
  logic [28:0]       s1_px_r, s1_py_r;
  logic [28:0]       px_nxt, py_nxt;
  logic              skip_nxt;

  assign px_nxt = {16'b0, in_col, 1'b1} * {13'b0, cfg.csize};
  assign py_nxt = {16'b0, in_row, 1'b1} * {13'b0, cfg.csize};
  assign skip_nxt = !cfg.en || (cfg.r == '0) || ({5'b0, in_col} >= GRID_LIM) ||
                    ({5'b0, in_row} >= GRID_LIM);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_col_r  <= in_col;
      s1_row_r  <= in_row;
      s1_old_r  <= in_old;
      s1_skip_r <= skip_nxt;
      s1_px_r   <= px_nxt;
      s1_py_r   <= py_nxt;
    end
  end

  // Stage 2: absolute doubled distance along each axis.
  logic [IDX_W-1:0]  s2_col_r, s2_row_r;
  logic [COST_W-1:0] s2_old_r;
  logic              s2_skip_r;
  logic [35:0]       s2_ax_r, s2_ay_r;
  logic [35:0]       dx_nxt, dy_nxt;

  assign dx_nxt = {{3{cfg.ox[31]}}, cfg.ox, 1'b0} + {7'b0, s1_px_r}
                - {{3{cfg.cx[31]}}, cfg.cx, 1'b0};
  assign dy_nxt = {{3{cfg.oy[31]}}, cfg.oy, 1'b0} + {7'b0, s1_py_r}
                - {{3{cfg.cy[31]}}, cfg.cy, 1'b0};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_old_r  <= s1_old_r;
      s2_skip_r <= s1_skip_r;
      s2_ax_r   <= dx_nxt[35] ? (36'd0 - dx_nxt) : dx_nxt;
      s2_ay_r   <= dy_nxt[35] ? (36'd0 - dy_nxt) : dy_nxt;
    end
  end

  // Stage 3: far-away test against three radii and the axis squares.
  logic [IDX_W-1:0]  s3_col_r, s3_row_r;
  logic [COST_W-1:0] s3_old_r;
  logic              s3_skip_r;
  logic [SQ_W-1:0]   s3_ax2_r, s3_ay2_r;
  logic [AX_W-1:0]   r3;
  logic              far;

  assign r3  = {2'b0, cfg.r} + {1'b0, cfg.r, 1'b0};
  assign far = (s2_ax_r > {14'b0, r3}) || (s2_ay_r > {14'b0, r3});

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_col_r  <= s2_col_r;
      s3_row_r  <= s2_row_r;
      s3_old_r  <= s2_old_r;
      s3_skip_r <= s2_skip_r || far;
      s3_ax2_r  <= s2_ax_r[AX_W-1:0] * s2_ax_r[AX_W-1:0];
      s3_ay2_r  <= s2_ay_r[AX_W-1:0] * s2_ay_r[AX_W-1:0];
    end
  end

  // Stage 4: squared doubled distance.
  logic [IDX_W-1:0]  s4_col_r, s4_row_r;
  logic [COST_W-1:0] s4_old_r;
  logic              s4_skip_r;
  logic [S_W-1:0]    s4_s_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_col_r  <= s3_col_r;
      s4_row_r  <= s3_row_r;
      s4_old_r  <= s3_old_r;
      s4_skip_r <= s3_skip_r;
      s4_s_r    <= {1'b0, s3_ax2_r} + {1'b0, s3_ay2_r};
    end
  end

  // Stage 5: scale by 255 squared.
  srch_t s5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_r.col    <= s4_col_r;
      s5_r.row    <= s4_row_r;
      s5_r.old    <= s4_old_r;
      s5_r.skip   <= s4_skip_r;
      s5_r.t      <= {16'b0, s4_s_r} * {45'b0, COST_SCALE_SQ};
      s5_r.acc    <= '0;
      s5_r.acc_cr <= '0;
    end
  end

  assign out_item = s5_r;
endmodule

// ===== rtl/core/rccs_sbit.sv =====
// One bit of the search for the largest k with (k*r)^2 below t.
module rccs_sbit import rccs_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RAD_W-1:0] radius,
  input  logic             in_valid,
  output logic             in_ready,
  input  srch_t            in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output srch_t            out_item
);
  logic [2:0] v_r;
  logic [3:0] rdy;

  always_comb begin
    rdy[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  srch_t           a_r, b_r, c_r;
  srch_t           c_nxt;
  logic [CR_W-1:0] a_cand_r, b_cand_r;
  logic [2*CR_W-1:0] b_sq_r;

  // Candidate product (acc | bit) * r, built by adding the shifted radius.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_r      <= in_item;
      a_cand_r <= in_item.acc_cr + ({{(CR_W-RAD_W){1'b0}}, radius} << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      b_r      <= a_r;
      b_cand_r <= a_cand_r;
      b_sq_r   <= a_cand_r * a_cand_r;
    end
  end

  always_comb begin
    c_nxt = b_r;
    if ({1'b0, b_sq_r} < b_r.t) begin
      c_nxt.acc    = b_r.acc | (K_W'(1) << BIT);
      c_nxt.acc_cr = b_cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c_r <= c_nxt;
    end
  end

  assign out_item = c_r;
endmodule

// ===== rtl/core/rccs_back.sv =====
// Final stage: cost from the search result, saturation and max with the old cost.
module rccs_back import rccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srch_t             in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_col,
  output logic [IDX_W-1:0]  out_row,
  output logic [COST_W-1:0] out_cost
);
  logic              v_r;
  logic [IDX_W-1:0]  col_r, row_r;
  logic [COST_W-1:0] cost_r;
  logic [K_W:0]      k, cost, sat;
  logic [COST_W-1:0] cost_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    // Smallest k with (k*r)^2 >= t is one above the search result, or zero.
    k    = (in_item.t == '0) ? '0 : ({1'b0, in_item.acc} + 11'd1);
    cost = K_LIMIT - k;
    sat  = (cost > COST_MAX) ? COST_MAX : cost;
    if (in_item.skip || (k > K_LIMIT)) begin
      cost_nxt = in_item.old;
    end else if (sat[COST_W-1:0] > in_item.old) begin
      cost_nxt = sat[COST_W-1:0];
    end else begin
      cost_nxt = in_item.old;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      col_r  <= in_item.col;
      row_r  <= in_item.row;
      cost_r <= cost_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_col   = col_r;
  assign out_row   = row_r;
  assign out_cost  = cost_r;
endmodule

// ===== rtl/core/radial_collision_cost_stamp.sv =====
// Top level of the radial collision cost stamp pipeline.
//
// Each input transaction is one costmap cell; the block returns the same
// cell with cost max(old, min(255, floor(255*(3 - 2d/r)))) where d is the
// distance from the cell center to the collision point, or the old cost when
// disabled, when the radius is zero, when the cell lies outside the grid or
// when the cost would be negative. The pipeline takes one transaction every
// clock unless the output stalls it, and is built from five front stages
// (center offset, axis distance, squares, sum, scaling by 255 squared), ten
// three-stage steps of a bitwise search for the largest k with (k*r)^2 < t
// (one adder, one 30x30 square and one compare per step), and one output
// register. Every stage has its own valid bit and ready is chained stage by
// stage, so empty stages keep filling while the output waits. Configuration
// writes are accepted in every cycle and must only be issued while no cell
// transaction is in flight.
`include "radial_collision_cost_stamp_assert.svh"
module radial_collision_cost_stamp import rccs_pkg::*; #(
  parameter int GRID_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  rccs_in_if.sink    in_ch,
  rccs_out_if.source out_ch,
  rccs_cfg_if.sink   cfg_ch
);
  cfg_t cfg_r;

  // Configuration registers; an unknown index is ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en    <= 1'b0;
      cfg_r.cx    <= '0;
      cfg_r.cy    <= '0;
      cfg_r.r     <= '0;
      cfg_r.ox    <= '0;
      cfg_r.oy    <= '0;
      cfg_r.csize <= CELL_SIZE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ENABLE:        cfg_r.en    <= cfg_ch.data[0];
        REG_CENTER_X:      cfg_r.cx    <= cfg_ch.data;
        REG_CENTER_Y:      cfg_r.cy    <= cfg_ch.data;
        REG_DANGER_RADIUS: cfg_r.r     <= cfg_ch.data[RAD_W-1:0];
        REG_GRID_ORIGIN_X: cfg_r.ox    <= cfg_ch.data;
        REG_GRID_ORIGIN_Y: cfg_r.oy    <= cfg_ch.data;
        REG_CELL_SIZE:     cfg_r.csize <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Link signals between the front, the ten search steps and the back.
  srch_t        link_item [K_W+1];
  logic [K_W:0] link_valid;
  logic [K_W:0] link_ready;

  rccs_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_col    (in_ch.cell_col),
    .in_row    (in_ch.cell_row),
    .in_old    (in_ch.old_cost),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_item  (link_item[0])
  );

  // The search decides k from the top bit down.
  for (genvar g = 0; g < K_W; g++) begin : g_search
    rccs_sbit #(.BIT(K_W-1-g)) u_sbit (
      .clk       (clk),
      .rst_n     (rst_n),
      .radius    (cfg_r.r),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_item   (link_item[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_item  (link_item[g+1])
    );
  end

  rccs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[K_W]),
    .in_ready  (link_ready[K_W]),
    .in_item   (link_item[K_W]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_col   (out_ch.out_col),
    .out_row   (out_ch.out_row),
    .out_cost  (out_ch.new_cost)
  );

  // An empty output stage means the whole ready chain is open.
  `RCCS_ASSERT(a_ready_when_out_empty, clk, rst_n, !out_ch.valid |-> in_ch.ready)
  // Reset flushes every stage, so nothing is offered right after it.
  `RCCS_ASSERT_ALWAYS(a_no_output_after_reset, clk, !rst_n |=> !out_ch.valid)
  // The front offers nothing to the search right after reset.
  `RCCS_ASSERT(a_front_empty_after_reset, clk, rst_n, $past(!rst_n) |-> !link_valid[0])
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the radial collision cost stamp pipeline.
module tb_top;
  import rccs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth, used as settle time after the last result.
  localparam int LATENCY     = 36;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  cost;
  } cell_t;

  // One row of the directed table: a cell and, where it is obvious, the cost.
  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  old;
    bit          typed;
    logic [7:0]  cost;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rccs_in_if  in_ch();
  rccs_out_if out_ch();
  rccs_cfg_if cfg_ch();

  radial_collision_cost_stamp DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // The testbench's own copy of the configuration registers.
  logic               m_en;
  logic signed [31:0] m_cx, m_cy, m_ox, m_oy;
  logic [19:0]        m_r;
  logic [15:0]        m_cell;

  cell_t pending_cells[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    raised_seen = 0;
  longint cycles = 0;
  bit    stall_pattern_on = 1'b0;

  // Smallest m with m*m >= t.
  function automatic longint unsigned ceil_root(longint unsigned t);
    longint unsigned res, bitv, v;
    res = 0;
    bitv = 64'd1 << 62;
    v = t;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (res * res != t) res++;
    return res;
  endfunction

  // Cost of one cell under the current register copy.
  function automatic logic [7:0] stamped_cost(logic [11:0] col, logic [11:0] row,
                                              logic [7:0] old);
    longint signed   dx, dy;
    longint unsigned ax, ay, r, s, m, k, c;
    r = m_r;
    if (!m_en || r == 0) return old;
    // Offsets are kept doubled so that the half-cell stays integral.
    dx = 2 * longint'(m_ox) + longint'((2 * longint'(col) + 1) * longint'(m_cell))
         - 2 * longint'(m_cx);
    dy = 2 * longint'(m_oy) + longint'((2 * longint'(row) + 1) * longint'(m_cell))
         - 2 * longint'(m_cy);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax > 3 * r || ay > 3 * r) return old;
    s = ax * ax + ay * ay;
    m = ceil_root(65025 * s);
    k = (m + r - 1) / r;
    if (k > 765) return old;
    c = 765 - k;
    if (c > 255) c = 255;
    return (c > old) ? c[7:0] : old;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Register write, issued only when nothing is in flight.
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ENABLE:        m_en   = val[0];
      REG_CENTER_X:      m_cx   = val;
      REG_CENTER_Y:      m_cy   = val;
      REG_DANGER_RADIUS: m_r    = val[19:0];
      REG_GRID_ORIGIN_X: m_ox   = val;
      REG_GRID_ORIGIN_Y: m_oy   = val;
      REG_CELL_SIZE:     m_cell = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Sends one cell; the expected result is queued at acceptance.
  task automatic send_cell(logic [11:0] col, logic [11:0] row, logic [7:0] old,
                           bit typed, logic [7:0] want);
    cell_t e;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.cell_col <= col;
    in_ch.cell_row <= row;
    in_ch.old_cost <= old;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e.col = col;
    e.row = row;
    e.cost = typed ? want : stamped_cost(col, row, old);
    if (typed && want != stamped_cost(col, row, old))
      $display("note: typed cost for cell %0d,%0d differs from prediction", col, row);
    pending_cells.push_back(e);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Random bursts: valid stays high across a burst, then usually a random gap.
  task automatic random_cells(int n, int near_pct);
    int left, burst;
    logic [11:0] c, r;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        // Cells near the hot spot exercise the arithmetic; others are noise.
        if ($urandom_range(0, 99) < near_pct) begin
          c = 12'($urandom_range(0, 40));
          r = 12'($urandom_range(0, 40));
        end else begin
          c = 12'($urandom);
          r = 12'($urandom);
        end
        send_cell(c, r, 8'($urandom), 1'b0, 8'd0);
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_input();
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
    idle_input();
  endtask

  // Receiver stall pattern: alternates between runs of steady ready and
  // stretches with random back-pressure.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_pattern_on <= ~stall_pattern_on;
    out_ch.ready <= stall_pattern_on ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // Result checker: each output transaction is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    cell_t e;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_cells.size() == 0) begin
        report_mismatch("result count", results_seen, results_seen - 1);
      end else begin
        e = pending_cells.pop_front();
        if (out_ch.out_col !== e.col) report_mismatch("out_col", out_ch.out_col, e.col);
        if (out_ch.out_row !== e.row) report_mismatch("out_row", out_ch.out_row, e.row);
        if (out_ch.new_cost !== e.cost)
          report_mismatch("new_cost", out_ch.new_cost, e.cost);
        if (e.cost == 8'd255) raised_seen++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  stim_row_t dir_tab[$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cell_col = '0;
    in_ch.cell_row = '0;
    in_ch.old_cost = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    m_en = 1'b0; m_cx = 0; m_cy = 0; m_r = '0; m_ox = 0; m_oy = 0;
    m_cell = CELL_SIZE_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset the block is disabled, so every cell keeps its cost.
    dir_tab = '{
      '{12'd0, 12'd0, 8'd0, 1'b1, 8'd0},
      '{12'd4095, 12'd4095, 8'd255, 1'b1, 8'd255},
      '{12'd2730, 12'd1365, 8'd170, 1'b1, 8'd170}
    };
    foreach (dir_tab[i])
      send_cell(dir_tab[i].col, dir_tab[i].row, dir_tab[i].old,
                dir_tab[i].typed, dir_tab[i].cost);
    idle_input();
    drain();

    // Enabled but radius still zero: no change either.
    write_reg(REG_ENABLE, 32'd1);
    send_cell(12'd0, 12'd0, 8'd3, 1'b1, 8'd3);
    idle_input();
    drain();

    // Collision point in the center of cell (0,0), cell size 1024, radius 4 m.
    write_reg(REG_CELL_SIZE, 32'd1024);
    write_reg(REG_CENTER_X, 32'd512);
    write_reg(REG_CENTER_Y, 32'd512);
    write_reg(REG_DANGER_RADIUS, 32'd4096);
    write_reg(REG_GRID_ORIGIN_X, 32'd0);
    write_reg(REG_GRID_ORIGIN_Y, 32'd0);
    dir_tab = '{
      '{12'd0, 12'd0, 8'd0, 1'b1, 8'd255},     // on the point: saturates
      '{12'd0, 12'd0, 8'd255, 1'b1, 8'd255},
      '{12'd4, 12'd0, 8'd0, 1'b0, 8'd0},       // at the radius
      '{12'd6, 12'd0, 8'd0, 1'b0, 8'd0},       // at one and a half radii
      '{12'd7, 12'd0, 8'd9, 1'b1, 8'd9},       // beyond: negative cost
      '{12'd5, 12'd3, 8'd100, 1'b0, 8'd0},
      '{12'd4095, 12'd4095, 8'd1, 1'b1, 8'd1}, // far corner
      '{12'd0, 12'd4095, 8'd0, 1'b1, 8'd0},
      '{12'd2, 12'd2, 8'd200, 1'b0, 8'd0}
    };
    foreach (dir_tab[i])
      send_cell(dir_tab[i].col, dir_tab[i].row, dir_tab[i].old,
                dir_tab[i].typed, dir_tab[i].cost);
    idle_input();
    drain();

    // Extremes: largest radius and most negative origin; then zero cell size.
    write_reg(REG_DANGER_RADIUS, 32'hFFFFF);
    write_reg(REG_GRID_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    send_cell(12'd0, 12'd0, 8'd7, 1'b1, 8'd7);
    send_cell(12'd4095, 12'd17, 8'd0, 1'b0, 8'd0);
    idle_input();
    drain();
    write_reg(REG_CELL_SIZE, 32'd0);
    write_reg(REG_GRID_ORIGIN_X, 32'd1000);
    write_reg(REG_CENTER_X, 32'd1000);
    write_reg(REG_GRID_ORIGIN_Y, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    send_cell(12'd4095, 12'd123, 8'd0, 1'b1, 8'd255);
    send_cell(12'd77, 12'd4095, 8'd255, 1'b1, 8'd255);
    idle_input();
    drain();

    // Random phases with fresh settings; each one ends with a full drain,
    // which also covers the pause until every result is back.
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_ENABLE, (p == 3) ? 32'd0 : 32'd1);
      write_reg(REG_CELL_SIZE, (p == 7) ? 32'hFFFF : 32'($urandom_range(1, 2000)));
      write_reg(REG_DANGER_RADIUS, (p == 5) ? 32'd1 : 32'($urandom_range(1, 40000)));
      write_reg(REG_GRID_ORIGIN_X, (p == 6) ? 32'h8000_0000 : 32'($urandom_range(0, 20000)) - 10000);
      write_reg(REG_GRID_ORIGIN_Y, (p == 6) ? 32'h7FFF_FFFF : 32'($urandom_range(0, 20000)) - 10000);
      write_reg(REG_CENTER_X, m_ox + 32'($urandom_range(0, 20) * m_cell));
      write_reg(REG_CENTER_Y, m_oy + 32'($urandom_range(0, 20) * m_cell));
      random_cells(80, 80);
      drain();
    end

    $display("covered %0d cell results, %0d of them at the saturated cost,", results_seen,
             raised_seen);
    $display("over directed extremes and eight random register settings");
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
